[design/lrd_pkg.sv]
// ----------------------------------------------------------------------------
// lrd_pkg: shared types and constants for the length/type record deframer
// Field, kind, error and record type codes, body field layouts, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package lrd_pkg;

	// record kind
	localparam logic [1:0] K_PREFIX  = 2'd0;
	localparam logic [1:0] K_HEADER  = 2'd1;
	localparam logic [1:0] K_SCANNER = 2'd2;
	localparam logic [1:0] K_EVENT   = 2'd3;

	// field codes
	localparam logic [4:0] F_LEN      = 5'd0;
	localparam logic [4:0] F_TYPE     = 5'd1;
	localparam logic [4:0] F_HDR_BASE = 5'd2;
	localparam logic [4:0] F_SCN_BASE = 5'd13;
	localparam logic [4:0] F_EVT_BASE = 5'd20;
	localparam logic [4:0] F_TRAIL    = 5'd22;
	localparam logic [4:0] F_DISCARD  = 5'd23;

	// error codes
	localparam logic [2:0] E_OK      = 3'd0;
	localparam logic [2:0] E_BAD_LEN = 3'd1;
	localparam logic [2:0] E_UNKNOWN = 3'd2;
	localparam logic [2:0] E_FOOTER  = 3'd3;
	localparam logic [2:0] E_HALTED  = 3'd4;

	// wire type codes
	localparam logic [15:0] TYPE_HEADER  = 16'd0;
	localparam logic [15:0] TYPE_SCANNER = 16'd3;
	localparam logic [15:0] TYPE_EVENT   = 16'd4;
	localparam logic [15:0] TYPE_FOOTER  = 16'd5;

	localparam logic [15:0] MIN_LEN    = 16'd4;
	localparam logic [15:0] PREFIX_LEN = 16'd4;
	localparam logic [7:0]  OFF_MAX    = 8'd255;

	// body layouts: start offset and length of each field
	localparam int HDR_N = 11;
	localparam int SCN_N = 7;
	localparam int EVT_N = 2;

	localparam logic [8:0] HDR_START [HDR_N] = '{
		9'd0, 9'd5, 9'd18, 9'd23, 9'd25, 9'd26, 9'd27, 9'd28, 9'd29, 9'd30, 9'd158};
	localparam logic [7:0] HDR_LEN [HDR_N] = '{
		8'd5, 8'd13, 8'd5, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd128, 8'd255};
	localparam logic [8:0] HDR_TOTAL = 9'd413;
	localparam int HDR_NUM = 3; // year

	localparam logic [8:0] SCN_START [SCN_N] = '{
		9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd8, 9'd9};
	localparam logic [7:0] SCN_LEN [SCN_N] = '{
		8'd1, 8'd1, 8'd1, 8'd2, 8'd3, 8'd1, 8'd2};
	localparam logic [8:0] SCN_TOTAL = 9'd11;
	localparam int SCN_NUM = 3; // millis

	localparam logic [8:0] EVT_START [EVT_N] = '{9'd0, 9'd3};
	localparam logic [7:0] EVT_LEN [EVT_N] = '{8'd3, 8'd255};
	localparam logic [8:0] EVT_TOTAL = 9'd258;
	localparam int EVT_NUM = 0; // event id

	typedef struct packed {
		logic [4:0] code;
		logic [7:0] off;
		logic       numeric;
		logic       last;
	} fmap_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [4:0]  field_code;
		logic [7:0]  field_offset;
		logic [7:0]  out_byte;
		logic [23:0] assembled_value;
		logic        value_complete;
		logic [15:0] record_length_out;
		logic [2:0]  error_code;
		logic        record_end;
	} result_t;

endpackage

`default_nettype wire

[design/lrd_field_map.sv]
// ----------------------------------------------------------------------------
// lrd_field_map: body byte position to field decode
// Maps a byte position after the prefix to field code, offset and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_field_map (
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] body_pos,
	output lrd_pkg::fmap_t   fmap
);

	logic        hit;
	logic [4:0]  sel;
	logic [8:0]  fstart;
	logic [7:0]  flen;
	logic [4:0]  base;
	logic [4:0]  num_sel;
	logic        has_num;
	logic [8:0]  total;
	logic [15:0] off_full;

	// descending scan so the lowest matching field wins
	always_comb begin
		hit     = 1'b0;
		sel     = '0;
		fstart  = '0;
		flen    = '0;
		base    = '0;
		num_sel = '0;
		has_num = 1'b0;
		total   = '0;
		case (kind)
			lrd_pkg::K_HEADER: begin
				base    = lrd_pkg::F_HDR_BASE;
				num_sel = 5'(lrd_pkg::HDR_NUM);
				has_num = 1'b1;
				total   = lrd_pkg::HDR_TOTAL;
				for (int i = lrd_pkg::HDR_N - 1; i >= 0; i--) begin
					if (body_pos < ({7'b0, lrd_pkg::HDR_START[i]} +
					                {8'b0, lrd_pkg::HDR_LEN[i]})) begin
						hit    = 1'b1;
						sel    = 5'(i);
						fstart = lrd_pkg::HDR_START[i];
						flen   = lrd_pkg::HDR_LEN[i];
					end
				end
			end
			lrd_pkg::K_SCANNER: begin
				base    = lrd_pkg::F_SCN_BASE;
				num_sel = 5'(lrd_pkg::SCN_NUM);
				has_num = 1'b1;
				total   = lrd_pkg::SCN_TOTAL;
				for (int i = lrd_pkg::SCN_N - 1; i >= 0; i--) begin
					if (body_pos < ({7'b0, lrd_pkg::SCN_START[i]} +
					                {8'b0, lrd_pkg::SCN_LEN[i]})) begin
						hit    = 1'b1;
						sel    = 5'(i);
						fstart = lrd_pkg::SCN_START[i];
						flen   = lrd_pkg::SCN_LEN[i];
					end
				end
			end
			lrd_pkg::K_EVENT: begin
				base    = lrd_pkg::F_EVT_BASE;
				num_sel = 5'(lrd_pkg::EVT_NUM);
				has_num = 1'b1;
				total   = lrd_pkg::EVT_TOTAL;
				for (int i = lrd_pkg::EVT_N - 1; i >= 0; i--) begin
					if (body_pos < ({7'b0, lrd_pkg::EVT_START[i]} +
					                {8'b0, lrd_pkg::EVT_LEN[i]})) begin
						hit    = 1'b1;
						sel    = 5'(i);
						fstart = lrd_pkg::EVT_START[i];
						flen   = lrd_pkg::EVT_LEN[i];
					end
				end
			end
			default: begin
				// no layout: everything is trailing
			end
		endcase

		if (hit) begin
			off_full     = body_pos - {7'b0, fstart};
			fmap.code    = base + sel;
			fmap.off     = off_full[7:0];
			fmap.numeric = has_num && (sel == num_sel);
			fmap.last    = (off_full[7:0] == (flen - 8'd1));
		end else begin
			off_full     = body_pos - {7'b0, total};
			fmap.code    = lrd_pkg::F_TRAIL;
			fmap.off     = (off_full > {8'b0, lrd_pkg::OFF_MAX}) ? lrd_pkg::OFF_MAX
			                                                     : off_full[7:0];
			fmap.numeric = 1'b0;
			fmap.last    = 1'b0;
		end
	end

endmodule

`default_nettype wire

[design/lrd_parse.sv]
// ----------------------------------------------------------------------------
// lrd_parse: record tracking state and per-beat result decode
// Holds position, length, type, remaining count, accumulator and halt flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_parse (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [7:0]  byte_in,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_value,
	output lrd_pkg::result_t res
);

	logic [15:0] pos_q;
	logic [15:0] rlen_q;
	logic [1:0]  rtype_q;
	logic [31:0] rem_q;
	logic [23:0] acc_q;
	logic        halted_q;

	logic [15:0] pos_n;
	logic [15:0] rlen_n;
	logic [1:0]  rtype_n;
	logic [31:0] rem_n;
	logic [23:0] acc_n;
	logic        halted_n;

	logic [15:0]    acc16;
	logic           rec_end;
	logic [15:0]    body_pos;
	lrd_pkg::fmap_t fmap;

	assign body_pos = pos_q - lrd_pkg::PREFIX_LEN;
	assign acc16    = {acc_q[7:0], byte_in};

	lrd_field_map u_fmap (
		.kind     (rtype_q),
		.body_pos (body_pos),
		.fmap     (fmap)
	);

	always_comb begin
		res          = '0;
		res.out_byte = byte_in;
		pos_n        = pos_q;
		rlen_n       = rlen_q;
		rtype_n      = rtype_q;
		rem_n        = rem_q;
		acc_n        = acc_q;
		halted_n     = halted_q;
		rec_end      = 1'b0;

		if (halted_q) begin
			res.field_code = lrd_pkg::F_DISCARD;
			res.error_code = lrd_pkg::E_HALTED;
		end else if (pos_q == '0 && rem_q == '0) begin
			res.field_code = lrd_pkg::F_DISCARD;
		end else begin
			rem_n = rem_q - {31'b0, (rem_q != '0)};
			if (pos_q[15:2] == '0) begin
				res.record_kind  = lrd_pkg::K_PREFIX;
				res.field_code   = pos_q[1] ? lrd_pkg::F_TYPE : lrd_pkg::F_LEN;
				res.field_offset = {7'b0, pos_q[0]};
				if (!pos_q[0]) begin
					acc_n = {16'b0, byte_in};
					if (!pos_q[1])
						rlen_n = '0;
				end else begin
					acc_n = {8'b0, acc16};
					res.value_complete = 1'b1;
					if (!pos_q[1]) begin
						rlen_n = acc16;
						// rem_q + 1 is the count left at the record start
						if (acc16 < lrd_pkg::MIN_LEN ||
						    {17'b0, acc16} > ({1'b0, rem_q} + 33'd1))
							res.error_code = lrd_pkg::E_BAD_LEN;
					end else begin
						case (acc16)
							lrd_pkg::TYPE_HEADER:  rtype_n = lrd_pkg::K_HEADER;
							lrd_pkg::TYPE_SCANNER: rtype_n = lrd_pkg::K_SCANNER;
							lrd_pkg::TYPE_EVENT:   rtype_n = lrd_pkg::K_EVENT;
							lrd_pkg::TYPE_FOOTER:  res.error_code = lrd_pkg::E_FOOTER;
							default:               res.error_code = lrd_pkg::E_UNKNOWN;
						endcase
						if (res.error_code == lrd_pkg::E_OK && rlen_q == lrd_pkg::MIN_LEN)
							rec_end = 1'b1;
					end
				end
				res.assembled_value = acc_n;
			end else begin
				res.record_kind  = rtype_q;
				res.field_code   = fmap.code;
				res.field_offset = fmap.off;
				if (fmap.numeric) begin
					acc_n = (fmap.off == '0) ? {16'b0, byte_in} : {acc_q[15:0], byte_in};
					res.assembled_value = acc_n;
					res.value_complete  = fmap.last;
				end else begin
					acc_n = '0;
				end
				if (({1'b0, pos_q} + 17'd1) == {1'b0, rlen_q})
					rec_end = 1'b1;
			end

			res.record_length_out = rlen_n;
			if (res.error_code != lrd_pkg::E_OK) begin
				halted_n = 1'b1;
			end else if (rec_end) begin
				res.record_end = 1'b1;
				pos_n          = '0;
			end else begin
				pos_n = pos_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			rlen_q   <= '0;
			rtype_q  <= '0;
			rem_q    <= '0;
			acc_q    <= '0;
			halted_q <= 1'b0;
		end else if (cfg_we) begin
			rem_q <= cfg_value;
		end else if (advance) begin
			pos_q    <= pos_n;
			rlen_q   <= rlen_n;
			rtype_q  <= rtype_n;
			rem_q    <= rem_n;
			acc_q    <= acc_n;
			halted_q <= halted_n;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag dropped");

	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && halted_q && !cfg_we) |=> ($stable(pos_q) && $stable(rem_q)))
		else $error("state moved while halted");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cfg_we && res.record_end) |=> (pos_q == '0))
		else $error("record end did not restart position");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance && !cfg_we) |=> ($stable(pos_q) && $stable(acc_q) && $stable(rem_q)))
		else $error("state changed without a beat");

endmodule

`default_nettype wire

[design/length_type_record_deframer_top.sv]
// ----------------------------------------------------------------------------
// length_type_record_deframer_top: length/type record deframer
// Splits a byte stream into records and labels each byte with its field.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / in_byte) takes one stream byte per
//    beat; output channel (out_valid / out_stall / result fields) gives
//    exactly one labeled result beat per input beat, in order.
//  - Config channel (cfg_valid / cfg_ready / cfg_data) loads the stream
//    length, which also reloads the remaining byte count. cfg_ready is always
//    high; write only while no byte is in flight.
//  - Path: an accepted input beat goes into the input register, then its
//    decode goes into the result register that drives the outputs.
//  - Throughput: one byte per cycle while the receiver does not stall; the
//    only loop is the per-byte update of the record state.
//  - Reset: all record state clears, remaining count is zero, so bytes are
//    discarded until a stream length is written.
//  - While the receiver stalls, the result register holds and the input
//    register fills; in_stall rises once both are occupied.
//  - Any error halts the block; every later byte is discarded with the halted
//    code until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module length_type_record_deframer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       record_kind,
	output logic [4:0]       field_code,
	output logic [7:0]       field_offset,
	output logic [7:0]       out_byte,
	output logic [23:0]      assembled_value,
	output logic             value_complete,
	output logic [15:0]      record_length_out,
	output logic [2:0]       error_code,
	output logic             record_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              valid_s2;
	lrd_pkg::result_t  res_s2;
	lrd_pkg::result_t  res;
	logic              advance;
	logic              in_fire;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_fire   = in_valid && !in_stall;

	lrd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_in   (byte_s1),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_value (cfg_data),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			byte_s1 <= in_byte;
		if (advance)
			res_s2 <= res;
	end

	assign out_valid         = valid_s2;
	assign record_kind       = res_s2.record_kind;
	assign field_code        = res_s2.field_code;
	assign field_offset      = res_s2.field_offset;
	assign out_byte          = res_s2.out_byte;
	assign assembled_value   = res_s2.assembled_value;
	assign value_complete    = res_s2.value_complete;
	assign record_length_out = res_s2.record_length_out;
	assign error_code        = res_s2.error_code;
	assign record_end        = res_s2.record_end;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the length/type record deframer
// Feeds framed trace records byte by byte: directed corner records, then random
// record sets under several stream lengths. It ends with one fatal framing
// error and a few halted bytes. A scoreboard predicts every result beat.
// ----------------------------------------------------------------------------

import lrd_pkg::*;

localparam int unsigned HDR_WIDTHS [11] = '{5, 13, 5, 2, 1, 1, 1, 1, 1, 128, 255};
localparam int unsigned SCN_WIDTHS [7]  = '{1, 1, 1, 2, 3, 1, 2};
localparam int unsigned EVT_WIDTHS [2]  = '{3, 255};

class deframe_scoreboard;
	result_t     want_q [$];
	int unsigned fails;
	logic [15:0] rec_pos;
	logic [15:0] rec_len;
	logic [1:0]  rec_kind;
	logic [31:0] remaining;
	logic [23:0] acc;
	bit          halted;

	function new();
		fails     = 0;
		rec_pos   = '0;
		rec_len   = '0;
		rec_kind  = K_PREFIX;
		remaining = '0;
		acc       = '0;
		halted    = 1'b0;
	endfunction

	function void load_length(logic [31:0] v);
		remaining = v;
	endfunction

	function int unsigned pending();
		return want_q.size();
	endfunction

	function int unsigned field_width(logic [1:0] kind, int unsigned idx);
		case (kind)
			K_HEADER:  return HDR_WIDTHS[idx];
			K_SCANNER: return SCN_WIDTHS[idx];
			default:   return EVT_WIDTHS[idx];
		endcase
	endfunction

	// work out the result beat for one accepted stream byte
	function void note_byte(logic [7:0] b);
		result_t     r;
		int unsigned pos, p, start, w, off, nf, base, numf, i;
		longint      rem0;
		logic [2:0]  err;
		bit          hit, fin;

		r = '0;
		r.out_byte = b;
		err = E_OK;
		fin = 1'b0;
		pos = rec_pos;
		if (halted) begin
			r.field_code = F_DISCARD;
			r.error_code = E_HALTED;
			want_q.push_back(r);
			return;
		end
		if (pos == 0 && remaining == 0) begin
			r.field_code = F_DISCARD;
			want_q.push_back(r);
			return;
		end
		rem0 = remaining;
		if (remaining != 0)
			remaining = remaining - 1;

		if (pos < 4) begin
			r.record_kind  = K_PREFIX;
			r.field_code   = (pos < 2) ? F_LEN : F_TYPE;
			r.field_offset = pos[0];
			if (!pos[0]) begin
				acc = {16'h0, b};
				if (pos == 0)
					rec_len = '0;
			end else begin
				acc = {8'h0, acc[7:0], b};
				r.value_complete = 1'b1;
				if (pos == 1) begin
					rec_len = acc[15:0];
					if (acc < MIN_LEN || longint'(acc) > rem0 + 1)
						err = E_BAD_LEN;
				end else begin
					case (acc[15:0])
						TYPE_HEADER:  rec_kind = K_HEADER;
						TYPE_SCANNER: rec_kind = K_SCANNER;
						TYPE_EVENT:   rec_kind = K_EVENT;
						TYPE_FOOTER:  err = E_FOOTER;
						default:      err = E_UNKNOWN;
					endcase
					if (err == E_OK && rec_len == PREFIX_LEN)
						fin = 1'b1;
				end
			end
			r.assembled_value = acc;
		end else begin
			p = pos - 4;
			start = 0;
			hit = 1'b0;
			case (rec_kind)
				K_HEADER: begin
					nf = HDR_N; base = F_HDR_BASE; numf = F_HDR_BASE + 3;
				end
				K_SCANNER: begin
					nf = SCN_N; base = F_SCN_BASE; numf = F_SCN_BASE + 3;
				end
				K_EVENT: begin
					nf = EVT_N; base = F_EVT_BASE; numf = F_EVT_BASE;
				end
				default: begin
					nf = 0; base = 0; numf = 32'hFFFF;
				end
			endcase
			r.record_kind = rec_kind;
			for (i = 0; i < nf && !hit; i++) begin
				w = field_width(rec_kind, i);
				if (p < start + w) begin
					off = p - start;
					r.field_code   = base + i;
					r.field_offset = off;
					if (base + i == numf) begin
						acc = (off == 0) ? {16'h0, b} : {acc[15:0], b};
						r.assembled_value = acc;
						r.value_complete  = (off + 1 == w);
					end else begin
						acc = '0;
					end
					hit = 1'b1;
				end else begin
					start += w;
				end
			end
			if (!hit) begin
				acc = '0;
				r.field_code   = F_TRAIL;
				r.field_offset = (p - start > 255) ? OFF_MAX : p - start;
			end
			if (pos + 1 == rec_len)
				fin = 1'b1;
		end

		r.record_length_out = rec_len;
		r.error_code = err;
		if (err != E_OK) begin
			halted = 1'b1;
		end else if (fin) begin
			r.record_end = 1'b1;
			rec_pos = '0;
		end else begin
			rec_pos = rec_pos + 1'b1;
		end
		want_q.push_back(r);
	endfunction

	function void compare(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	function void check_result(result_t got);
		result_t want;

		if (want_q.size() == 0) begin
			$error("result beat with no byte pending");
			fails++;
			return;
		end
		want = want_q.pop_front();
		compare("record_kind", want.record_kind, got.record_kind);
		compare("field_code", want.field_code, got.field_code);
		compare("field_offset", want.field_offset, got.field_offset);
		compare("out_byte", want.out_byte, got.out_byte);
		compare("assembled_value", want.assembled_value, got.assembled_value);
		compare("value_complete", want.value_complete, got.value_complete);
		compare("record_length_out", want.record_length_out, got.record_length_out);
		compare("error_code", want.error_code, got.error_code);
		compare("record_end", want.record_end, got.record_end);
	endfunction
endclass

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RANDOM_BYTES = 500;

	typedef enum {BREAK_SHORT, BREAK_LONG, BREAK_TYPE, BREAK_FOOTER} break_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  record_kind;
	logic [4:0]  field_code;
	logic [7:0]  field_offset;
	logic [7:0]  out_byte;
	logic [23:0] assembled_value;
	logic        value_complete;
	logic [15:0] record_length_out;
	logic [2:0]  error_code;
	logic        record_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	deframe_scoreboard sb;
	bit          tx_burst;
	bit          rx_burst;
	bit          hold_rx;
	bit          random_phase;
	int unsigned cycles;

	length_type_record_deframer_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.record_kind      (record_kind),
		.field_code       (field_code),
		.field_offset     (field_offset),
		.out_byte         (out_byte),
		.assembled_value  (assembled_value),
		.value_complete   (value_complete),
		.record_length_out(record_length_out),
		.error_code       (error_code),
		.record_end       (record_end),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin : watchdog
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[length_type_record_deframer_top] ERROR");
				$finish;
			end
		end
	end

	// receiver: check each accepted beat, then stall a drawn number of cycles
	initial begin : rx_side
		int unsigned rx_wait;
		rx_wait = 0;
		rx_burst = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result({record_kind, field_code, field_offset, out_byte,
					assembled_value, value_complete, record_length_out, error_code,
					record_end});
				if ($urandom_range(0, 63) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 18);
			end
			@(negedge clk);
			out_stall <= hold_rx || (rx_wait != 0);
			if (rx_wait != 0)
				rx_wait--;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin : rx_pressure
		hold_rx = 1'b0;
		wait (random_phase);
		repeat ($urandom_range(50, 300)) @(posedge clk);
		hold_rx = 1'b1;
		repeat (400) @(posedge clk);
		hold_rx = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if ($urandom_range(0, 63) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 18);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b);
	endtask

	task automatic send_record(input logic [15:0] len, input logic [15:0] typ,
			input int unsigned body_n);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(typ[15:8]);
		send_byte(typ[7:0]);
		repeat (body_n)
			send_byte($urandom_range(0, 255));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_stream_length(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.load_length(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly short records; now and then one long enough to reach the tail
	task automatic pick_record(output logic [15:0] len, output logic [15:0] typ);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case ($urandom_range(0, 2))
			0: begin
				typ = TYPE_HEADER;
				len = (roll < 85) ? $urandom_range(4, 40) :
					(roll < 97) ? $urandom_range(4, 200) : $urandom_range(400, 440);
			end
			1: begin
				typ = TYPE_SCANNER;
				len = $urandom_range(4, 20);
			end
			default: begin
				typ = TYPE_EVENT;
				len = (roll < 80) ? $urandom_range(4, 20) :
					(roll < 95) ? $urandom_range(4, 270) : $urandom_range(255, 540);
			end
		endcase
	endtask

	initial begin : stimulus
		int unsigned dir_len [8];
		logic [15:0] dir_typ [8];
		logic [15:0] len_q [$];
		logic [15:0] typ_q [$];
		logic [15:0] len, typ, bad;
		int unsigned total, rand_bytes, n, k, spare;
		bit          max_mode;
		break_e      brk;

		sb = new();
		tx_burst = 1'b0;
		random_phase = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// nothing loaded yet: every byte is dropped
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);

		// corner records: length-4 record, full header with tail, exact and long
		// scanner, cut in millis, cut in event id, saturating event tail, short header
		dir_len = '{4, 420, 15, 17, 8, 5, 522, 30};
		dir_typ = '{TYPE_HEADER, TYPE_HEADER, TYPE_SCANNER, TYPE_SCANNER, TYPE_SCANNER,
			TYPE_EVENT, TYPE_EVENT, TYPE_HEADER};
		total = 0;
		foreach (dir_len[i])
			total += dir_len[i];
		wait_idle();
		write_stream_length(total);
		foreach (dir_len[i])
			send_record(dir_len[i], dir_typ[i], dir_len[i] - 4);
		send_byte(8'h00);
		send_byte(8'hFF);

		wait_idle();
		write_stream_length(32'h0);
		send_byte(8'h80);
		send_byte(8'h7F);

		random_phase = 1'b1;
		rand_bytes = 0;
		while (rand_bytes < RANDOM_BYTES) begin
			n = $urandom_range(3, 12);
			total = 0;
			for (k = 0; k < n; k++) begin
				pick_record(len, typ);
				len_q.push_back(len);
				typ_q.push_back(typ);
				total += len;
			end
			max_mode = ($urandom_range(0, 3) == 0);
			tx_burst = ($urandom_range(0, 3) == 0);
			wait_idle();
			write_stream_length(max_mode ? 32'hFFFF_FFFF : total);
			for (k = 0; k < n; k++)
				send_record(len_q[k], typ_q[k], len_q[k] - 4);
			rand_bytes += total;
			if (!max_mode && $urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3))
					send_byte($urandom_range(0, 255));
			len_q.delete();
			typ_q.delete();
		end

		// one good record, then a broken one; the block halts for good
		wait_idle();
		pick_record(len, typ);
		spare = $urandom_range(4, 60);
		write_stream_length(len + spare);
		send_record(len, typ, len - 4);
		brk = break_e'($urandom_range(0, 3));
		case (brk)
			BREAK_SHORT:
				send_record($urandom_range(0, 3), TYPE_HEADER, 0);
			BREAK_LONG:
				send_record(($urandom_range(0, 1) != 0) ? 16'hFFFF :
					spare + 1 + $urandom_range(0, 200), TYPE_EVENT, 0);
			BREAK_TYPE: begin
				do
					bad = $urandom_range(0, 65535);
				while (bad == TYPE_HEADER || bad == TYPE_SCANNER || bad == TYPE_EVENT ||
					bad == TYPE_FOOTER);
				send_record($urandom_range(4, spare), bad, 0);
			end
			default:
				send_record($urandom_range(4, spare), TYPE_FOOTER, 0);
		endcase
		repeat (6)
			send_byte($urandom_range(0, 255));

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.fails == 0)
			$display("[length_type_record_deframer_top] OK");
		else
			$display("[length_type_record_deframer_top] ERROR");
		$finish;
	end

endmodule

[files.f]
design/lrd_pkg.sv
design/lrd_field_map.sv
design/lrd_parse.sv
design/length_type_record_deframer_top.sv
tb/tb_top.sv
